// File: design/dq_pkg.sv
// Shared types and constants for the circular deque.
// The cell row and the top level both use this package.
package dq_pkg;

  // Entry width and capacity register width.
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int DEPTH_DEF = 16;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Value shown at both ends of an empty deque.
  localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

  // Configuration register indexes.
  localparam logic REG_CAPACITY = 1'b0;

  // Commands carried by an input item.
  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_DEL_FRONT = 2'd2,
    CMD_DEL_BACK  = 2'd3
  } dq_cmd_t;

  // Per-cycle control broadcast to every cell of the row.
  typedef struct packed {
    logic              ins_front;
    logic              ins_back;
    logic              del_front;
    logic              del_back;
    logic [DATA_W-1:0] value;
  } dq_ctl_t;

endpackage

// File: design/dq_cell.sv
// One storage cell of the deque row: an entry and its valid bit.
// Depends on dq_pkg; the top level chains DEPTH of these cells.
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dq_ctl_t           ctl,
  input  logic              left_valid,
  input  logic [DATA_W-1:0] left_data,
  input  logic              right_valid,
  input  logic [DATA_W-1:0] right_data,
  output logic              valid,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] back_tap
);

  // Valid bits form a thermometer: inserts shift a one in from the front,
  // deletes shift a zero in from the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (ctl.ins_front || ctl.ins_back) begin
        valid <= left_valid;
      end else if (ctl.del_front || ctl.del_back) begin
        valid <= right_valid;
      end else begin
        valid <= valid;
      end
    end
  end

  // Front insert shifts entries toward the back, front delete shifts them
  // toward the front, and a back insert fills the first empty cell.
  always_ff @(posedge clk) begin
    priority if (ctl.ins_front) begin
      data <= left_data;
    end else if (ctl.ins_back && !valid && left_valid) begin
      data <= ctl.value;
    end else if (ctl.del_front) begin
      data <= right_data;
    end else begin
      data <= data;
    end
  end

  // The last occupied cell offers its entry as the back value.
  assign back_tap = (valid && !right_valid) ? data : '0;

endmodule

// File: design/circular_deque.sv
// Circular deque: a double-ended queue held in a row of shifting cells.
// An accepted item updates the cell row and sets the pending flag; the result
// register is then loaded from the updated row. The input is held off while
// the pending flag is set, and while a result waits.
// Reset (synchronous, active high) empties the deque and sets capacity to 16.
// Depends on dq_pkg and dq_cell.
module circular_deque
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input item, fields from bit 0: command[1:0], value[33:2], zero pad.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // Result item, fields from bit 0: ok[0], is_empty[1], is_full[2],
  // front_value[34:3], back_value[66:35], zero pad.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  occupancy;
  logic              pending;
  logic              pending_ok;

  logic              out_valid;
  logic              out_ok;
  logic              out_empty;
  logic              out_full;
  logic [DATA_W-1:0] out_front;
  logic [DATA_W-1:0] out_back;

  dq_cmd_t           command;
  logic [DATA_W-1:0] value;
  logic              accept;
  logic              cmd_ok;
  logic [CMP_W-1:0]  eff_cap;
  logic [CMP_W-1:0]  occ_ext;
  dq_ctl_t           ctl;

  logic [DEPTH-1:0]  cell_valid;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tap  [DEPTH];
  logic [DATA_W-1:0] back_sel;

  // Configuration register; reads at its index return the capacity, others zero.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Input item decode and success test against the effective capacity.
  assign command = dq_cmd_t'(s_tdata[1:0]);
  assign value   = s_tdata[33:2];
  assign s_tready = !pending && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign eff_cap = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
  assign occ_ext = CMP_W'(occupancy);

  always_comb begin
    cmd_ok = 1'b0;
    unique case (command)
      CMD_INS_FRONT, CMD_INS_BACK: cmd_ok = (occ_ext < eff_cap);
      CMD_DEL_FRONT, CMD_DEL_BACK: cmd_ok = (occupancy != '0);
      default:                     cmd_ok = 1'b0;
    endcase
  end

  // Control broadcast to the cell row; only successful commands act.
  always_comb begin
    ctl           = '0;
    ctl.value     = value;
    ctl.ins_front = accept && cmd_ok && (command == CMD_INS_FRONT);
    ctl.ins_back  = accept && cmd_ok && (command == CMD_INS_BACK);
    ctl.del_front = accept && cmd_ok && (command == CMD_DEL_FRONT);
    ctl.del_back  = accept && cmd_ok && (command == CMD_DEL_BACK);
  end

  // Occupancy count and the evaluate flag for the cycle after an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      pending   <= 1'b0;
    end else begin
      pending <= accept;
      if (ctl.ins_front || ctl.ins_back) begin
        occupancy <= occupancy + CNT_W'(1);
      end else if (ctl.del_front || ctl.del_back) begin
        occupancy <= occupancy - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_ok <= cmd_ok;
    end
  end

  // Row of cells; cell 0 holds the front entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lv;
    logic [DATA_W-1:0] ld;
    logic              rv;
    logic [DATA_W-1:0] rd;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = value;
    end else begin : g_inner_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_inner_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[i]),
      .data        (cell_data[i]),
      .back_tap    (cell_tap[i])
    );
  end

  // At most one cell marks itself last, so an OR over the taps selects it.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | cell_tap[i];
    end
  end

  // Result register, loaded in the cycle after the item is accepted, from the updated row.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pending) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      out_ok    <= pending_ok;
      out_empty <= (occupancy == '0);
      out_full  <= (occ_ext >= eff_cap);
      out_front <= (occupancy == '0) ? EMPTY_MARK : cell_data[0];
      out_back  <= (occupancy == '0) ? EMPTY_MARK : back_sel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_back, out_front, out_full, out_empty, out_ok};

`ifndef SYNTH
  // A raised pending flag is always followed by a valid result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    pending |=> m_tvalid)
    else $error("result missing after accepted item");

  // The count never exceeds the number of cells.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ_ext <= CMP_W'(DEPTH))
    else $error("occupancy above depth");

  // The valid bits of the row agree with the occupancy count.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(occupancy))
    else $error("cell valid bits disagree with occupancy");

  // Valid bits stay a thermometer from the front cell.
  a_thermo: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid & ~(cell_valid << 1)) && (cell_valid[0] || cell_valid == '0))
    else $error("cell valid bits not contiguous from the front");
`endif

endmodule

// File: verif/circular_deque_tb.sv
// Self-checking testbench for circular_deque: stream commands in, results out.
// Predicts each result from its own deque model and writes capacity over APB.
// Depends on dq_pkg and the circular_deque RTL.
`timescale 1ns / 1ps

module circular_deque_tb
  import dq_pkg::*;
();

  localparam int IDX_W      = $clog2(DEPTH_DEF);
  localparam int STALL_MAX  = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int HOLD_AT    = 500;

  typedef struct packed {
    dq_cmd_t           cmd;
    logic [DATA_W-1:0] value;
  } dq_item_t;

  typedef struct packed {
    logic              ok;
    logic              is_empty;
    logic              is_full;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
  } dq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // Fields from bit 0: command[1:0], value[33:2], zero pad.
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // Fields from bit 0: ok[0], is_empty[1], is_full[2], front_value[34:3],
  // back_value[66:35], zero pad.
  logic [71:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  circular_deque u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Deque model state and the capacity it currently obeys.
  logic [DATA_W-1:0] dq_ring [DEPTH_DEF];
  logic [IDX_W-1:0]  dq_head = '0;
  logic [IDX_W-1:0]  dq_tail = '0;
  logic [CAP_W-1:0]  dq_count = '0;
  logic [CAP_W-1:0]  dq_capacity = CAP_RESET;

  dq_item_t   pending_cmds[$];
  dq_result_t expected_results[$];
  dq_item_t   cur_item;
  int         idle_pct = 0;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         results_seen = 0;
  bit         long_hold_done = 1'b0;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one command to the model and return the result it produces.
  function automatic dq_result_t apply_command(dq_cmd_t cmd, logic [DATA_W-1:0] value);
    dq_result_t       r;
    logic [CAP_W-1:0] lim;
    logic [IDX_W-1:0] last;
    lim  = (dq_capacity > DEPTH_DEF) ? CAP_W'(DEPTH_DEF) : dq_capacity;
    r    = '0;
    case (cmd)
      CMD_INS_FRONT: begin
        if (dq_count < lim) begin
          dq_head = dq_head - 1'b1;
          dq_ring[dq_head] = value;
          dq_count = dq_count + 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_INS_BACK: begin
        if (dq_count < lim) begin
          dq_ring[dq_tail] = value;
          dq_tail = dq_tail + 1'b1;
          dq_count = dq_count + 1'b1;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_FRONT: begin
        if (dq_count != 0) begin
          dq_head = dq_head + 1'b1;
          dq_count = dq_count - 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (dq_count != 0) begin
          dq_tail = dq_tail - 1'b1;
          dq_count = dq_count - 1'b1;
          r.ok = 1'b1;
        end
      end
    endcase
    last = dq_tail - 1'b1;
    r.is_empty = (dq_count == 0);
    r.is_full  = (dq_count >= lim);
    r.front_value = r.is_empty ? EMPTY_MARK : dq_ring[dq_head];
    r.back_value  = r.is_empty ? EMPTY_MARK : dq_ring[last];
    return r;
  endfunction

  // Driver: presents queued items, holds them until taken, inserts idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_command(cur_item.cmd, cur_item.value));
      end
      if (s_tvalid && !s_tready) begin
        // Item still waiting to be taken: keep it on the bus.
      end else if (src_gap != 0) begin
        src_gap = src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0 && idle_pct != 0 &&
                   $urandom_range(99) < idle_pct) begin
        src_gap = $urandom_range(16);
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cur_item = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, cur_item.value, cur_item.cmd};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and paces tready.
  always @(posedge clk) begin
    dq_result_t want;
    dq_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen = results_seen + 1;
        got.ok          = m_tdata[0];
        got.is_empty    = m_tdata[1];
        got.is_full     = m_tdata[2];
        got.front_value = m_tdata[34:3];
        got.back_value  = m_tdata[66:35];
        if (expected_results.size() == 0) begin
          $error("result item with no expected result pending");
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0h, got %0h", want.ok, got.ok);
            fail_count = fail_count + 1;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0h, got %0h", want.is_empty, got.is_empty);
            fail_count = fail_count + 1;
          end
          if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0h, got %0h", want.is_full, got.is_full);
            fail_count = fail_count + 1;
          end
          if (got.front_value !== want.front_value) begin
            $error("front_value: expected %0h, got %0h", want.front_value,
                   got.front_value);
            fail_count = fail_count + 1;
          end
          if (got.back_value !== want.back_value) begin
            $error("back_value: expected %0h, got %0h", want.back_value,
                   got.back_value);
            fail_count = fail_count + 1;
          end
        end
      end
      // One long hold-off lets the block fill up and stall its input.
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        sink_gap = LONG_HOLD;
      end
      if (sink_gap != 0) begin
        sink_gap = sink_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        sink_gap = $urandom_range(16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_cmd(input dq_cmd_t cmd, input logic [DATA_W-1:0] value);
    pending_cmds.push_back('{cmd, value});
  endtask

  // Waits until every queued item is sent and every result has come back.
  // The state is sampled mid-cycle so the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0 ||
           m_tvalid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the capacity register once the block is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dq_capacity = cap;
  endtask

  // Runs of mostly inserts or mostly deletes so the deque swings between
  // empty and full, with a share of random commands mixed in.
  task automatic queue_random_cmds(input int count);
    int                left;
    int                run_len;
    bit                grow;
    bit                pick_ins;
    dq_cmd_t           cmd;
    logic [DATA_W-1:0] value;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(1, 24);
      grow = 1'($urandom_range(1));
      while (run_len > 0 && left > 0) begin
        pick_ins = ($urandom_range(99) < 80) ? grow : 1'($urandom_range(1));
        if (pick_ins)
          cmd = $urandom_range(1) ? CMD_INS_BACK : CMD_INS_FRONT;
        else
          cmd = $urandom_range(1) ? CMD_DEL_BACK : CMD_DEL_FRONT;
        case ($urandom_range(15))
          0:       value = 32'h7FFF_FFFF;
          1:       value = 32'h8000_0000;
          2:       value = '0;
          3:       value = '1;
          default: value = $urandom;
        endcase
        queue_cmd(cmd, value);
        run_len = run_len - 1;
        left = left - 1;
      end
    end
  endtask

  // Stimulus sequence: directed cases, then random phases over many capacities.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty-deque deletes, extreme values at both ends, back to empty.
    queue_cmd(CMD_DEL_FRONT, 32'h0);
    queue_cmd(CMD_DEL_BACK, 32'hFFFF_FFFF);
    queue_cmd(CMD_INS_FRONT, 32'h7FFF_FFFF);
    queue_cmd(CMD_INS_BACK, 32'h8000_0000);
    queue_cmd(CMD_INS_FRONT, 32'h0);
    queue_cmd(CMD_DEL_BACK, 32'h1234_5678);
    queue_cmd(CMD_DEL_FRONT, 32'h0);
    queue_cmd(CMD_DEL_FRONT, 32'h0);
    queue_cmd(CMD_DEL_BACK, 32'h0);

    // Small capacity: insert into a full deque fails.
    set_capacity(CAP_W'(2));
    queue_cmd(CMD_INS_BACK, 32'hFFFF_FFFF);
    queue_cmd(CMD_INS_FRONT, 32'h5555_AAAA);
    queue_cmd(CMD_INS_BACK, 32'hAAAA_5555);
    queue_cmd(CMD_DEL_FRONT, 32'h0);
    queue_cmd(CMD_DEL_BACK, 32'h0);
    queue_cmd(CMD_DEL_BACK, 32'h0);

    // Zero capacity: every insert fails and the empty deque reads full.
    set_capacity(CAP_W'(0));
    queue_cmd(CMD_INS_FRONT, 32'h0000_0001);
    queue_cmd(CMD_INS_BACK, 32'h0000_0002);
    queue_cmd(CMD_DEL_FRONT, 32'h0);

    // Capacity lowered below occupancy: entries are kept, inserts fail
    // until deletes bring the count under the new limit.
    set_capacity(CAP_W'(16));
    queue_cmd(CMD_INS_BACK, 32'h0000_0011);
    queue_cmd(CMD_INS_BACK, 32'h0000_0022);
    queue_cmd(CMD_INS_FRONT, 32'h0000_0033);
    queue_cmd(CMD_INS_BACK, 32'h0000_0044);
    queue_cmd(CMD_INS_FRONT, 32'h0000_0055);
    set_capacity(CAP_W'(2));
    queue_cmd(CMD_INS_FRONT, 32'h0000_0066);
    queue_cmd(CMD_DEL_BACK, 32'h0);
    queue_cmd(CMD_DEL_FRONT, 32'h0);
    queue_cmd(CMD_DEL_BACK, 32'h0);
    queue_cmd(CMD_DEL_FRONT, 32'h0);

    // Random phases; occupancy carries over from one capacity to the next.
    idle_pct = 25;
    set_capacity(CAP_W'(1));
    queue_random_cmds(120);
    set_capacity(CAP_W'(16));
    queue_random_cmds(200);
    idle_pct = 0;
    set_capacity(CAP_W'(31));
    queue_random_cmds(200);
    idle_pct = 20;
    set_capacity(CAP_W'(0));
    queue_random_cmds(30);
    set_capacity(CAP_W'(17));
    queue_random_cmds(150);
    idle_pct = 30;
    set_capacity(CAP_W'($urandom_range(1, 16)));
    queue_random_cmds(150);
    idle_pct = 10;
    set_capacity(CAP_W'(3));
    queue_random_cmds(150);
    idle_pct = 25;
    set_capacity(CAP_W'($urandom_range(0, 31)));
    queue_random_cmds(150);

    // Closing phase at full rate with no idling on either side.
    idle_pct = 0;
    set_capacity(CAP_W'(16));
    queue_random_cmds(250);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
